FILE: rtl/core/jaf_pkg.sv
// Shared types and constants of the JPEG APP1 metadata filter.
// Holds marker codes, signature tables and the front-to-back command word.
// No dependencies.
package jaf_pkg;

  localparam int CNT_W = 6;

  localparam logic [7:0] MK_FF   = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_APP1 = 8'hE1;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;

  localparam logic [CNT_W-1:0] EXIF_LEN = 6'd6;
  localparam logic [CNT_W-1:0] XMP_LEN  = 6'd28;
  localparam logic [CNT_W-1:0] HDR_LEN  = 6'd4;

  localparam logic [7:0] EXIF_SIG [8] = '{
    8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] XMP_SIG [32] = '{
    8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h6E,
    8'h73, 8'h2E, 8'h61, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2E,
    8'h63, 8'h6F, 8'h6D, 8'h2F, 8'h78, 8'h61, 8'h70, 8'h2F,
    8'h31, 8'h2E, 8'h30, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic             keep;
    logic [CNT_W-1:0] n;
    logic             last;
    logic             status;
  } cmd_t;

  typedef struct packed {
    logic       we;
    logic [7:0] data;
  } ring_wr_t;

endpackage

FILE: rtl/core/jaf_front.sv
// Front end: parses the byte stream and classifies each segment.
// Pushes kept and dropped bytes to the byte ring; issues keep/drop commands.
// Depends on jaf_pkg.
module jaf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           strip_exif_i,
  input  logic           strip_xmp_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic           ring_full_i,
  input  logic           cmd_full_i,
  output jaf_pkg::ring_wr_t wr_o,
  output logic           cmd_push_o,
  output jaf_pkg::cmd_t  cmd_o
);
  import jaf_pkg::*;

  localparam logic [3:0] PH_SOI0  = 4'd0;
  localparam logic [3:0] PH_SOI1  = 4'd1;
  localparam logic [3:0] PH_BAD   = 4'd2;
  localparam logic [3:0] PH_MARK0 = 4'd3;
  localparam logic [3:0] PH_MARK1 = 4'd4;
  localparam logic [3:0] PH_LEN0  = 4'd5;
  localparam logic [3:0] PH_LEN1  = 4'd6;
  localparam logic [3:0] PH_APP1  = 4'd7;
  localparam logic [3:0] PH_BODY  = 4'd8;
  localparam logic [3:0] PH_PASS  = 4'd9;

  typedef enum logic [1:0] {ACT_HOLD, ACT_KEEP, ACT_DROP} act_e;

  logic [3:0]       phase_q, phase_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic [15:0]      bl_q, bl_d;
  logic             exif_q, exif_d;
  logic             xmp_q, xmp_d;
  logic             drop_q, drop_d;
  logic             bad_q, bad_d;
  logic             app1_q, app1_d;

  logic             acc;
  logic             push;
  act_e             act, act_f;
  logic             bad_f;
  logic [CNT_W-1:0] pend_add;
  logic [15:0]      len_w;
  logic [15:0]      bl_len;
  logic [15:0]      bl_dec;
  logic [CNT_W-1:0] k;
  logic             ex_n, xm_n;

  assign in_ready_o = !ring_full_i && !cmd_full_i;
  assign acc        = in_valid_i && in_ready_o;

  assign len_w  = {bl_q[15:8], in_byte_i};
  assign bl_len = (len_w < 16'd2) ? 16'd0 : len_w - 16'd2;
  assign bl_dec = (bl_q != 16'd0) ? bl_q - 16'd1 : bl_q;
  assign k      = pend_q - HDR_LEN;

  always_comb begin
    ex_n = exif_q && (k < EXIF_LEN) && (in_byte_i == EXIF_SIG[k[2:0]]);
    xm_n = xmp_q && !((k < XMP_LEN) && (in_byte_i != XMP_SIG[k[4:0]]));
  end

  always_comb begin
    phase_d = phase_q;
    bl_d    = bl_q;
    exif_d  = exif_q;
    xmp_d   = xmp_q;
    drop_d  = drop_q;
    bad_d   = bad_q;
    app1_d  = app1_q;
    act     = ACT_HOLD;
    push    = 1'b1;
    unique case (phase_q)
      PH_SOI0: begin
        if (in_byte_i == MK_FF) begin
          phase_d = PH_SOI1;
        end else begin
          bad_d   = 1'b1;
          phase_d = PH_BAD;
          act     = ACT_DROP;
        end
      end
      PH_SOI1: begin
        if (in_byte_i == MK_SOI) begin
          phase_d = PH_MARK0;
          act     = ACT_KEEP;
        end else begin
          bad_d   = 1'b1;
          phase_d = PH_BAD;
          act     = ACT_DROP;
        end
      end
      PH_BAD: begin
        push = 1'b0;
      end
      PH_MARK0: begin
        if (in_byte_i == MK_FF) begin
          phase_d = PH_MARK1;
        end else begin
          phase_d = PH_PASS;
          act     = ACT_KEEP;
        end
      end
      PH_MARK1: begin
        if (in_byte_i == MK_SOS || in_byte_i == MK_EOI) begin
          phase_d = PH_PASS;
          act     = ACT_KEEP;
        end else if (in_byte_i inside {8'h00, 8'h01, [MK_RST0:MK_RST7]}) begin
          phase_d = PH_MARK0;
          act     = ACT_KEEP;
        end else begin
          app1_d  = (in_byte_i == MK_APP1);
          exif_d  = (in_byte_i == MK_APP1) && strip_exif_i;
          xmp_d   = (in_byte_i == MK_APP1) && strip_xmp_i;
          phase_d = PH_LEN0;
        end
      end
      PH_LEN0: begin
        bl_d    = {in_byte_i, bl_q[7:0]};
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        bl_d   = bl_len;
        exif_d = exif_q && (bl_len >= 16'(EXIF_LEN));
        xmp_d  = xmp_q && (bl_len >= 16'(XMP_LEN));
        drop_d = 1'b0;
        if (app1_q && (exif_d || xmp_d)) begin
          phase_d = PH_APP1;
        end else begin
          act     = ACT_KEEP;
          phase_d = (bl_len != 16'd0) ? PH_BODY : PH_MARK0;
        end
      end
      PH_APP1: begin
        exif_d = ex_n;
        xmp_d  = xm_n;
        bl_d   = bl_dec;
        if ((ex_n && k == EXIF_LEN - 6'd1) || (xm_n && k == XMP_LEN - 6'd1)) begin
          act     = ACT_DROP;
          drop_d  = (bl_dec != 16'd0);
          phase_d = (bl_dec != 16'd0) ? PH_BODY : PH_MARK0;
        end else if ((!ex_n && !xm_n) || bl_dec == 16'd0 || k >= XMP_LEN - 6'd1) begin
          act     = ACT_KEEP;
          drop_d  = 1'b0;
          phase_d = (bl_dec != 16'd0) ? PH_BODY : PH_MARK0;
        end
      end
      PH_BODY: begin
        act  = drop_q ? ACT_DROP : ACT_KEEP;
        bl_d = bl_dec;
        if (bl_dec == 16'd0) begin
          drop_d  = 1'b0;
          phase_d = PH_MARK0;
        end
      end
      default: begin
        act = ACT_KEEP;
      end
    endcase
  end

  always_comb begin
    act_f = act;
    bad_f = bad_d;
    if (in_last_i) begin
      if (phase_d == PH_SOI0 || phase_d == PH_SOI1) begin
        bad_f = 1'b1;
      end
      if (act == ACT_HOLD) begin
        act_f = (phase_d == PH_SOI0 || phase_d == PH_SOI1) ? ACT_DROP : ACT_KEEP;
      end
    end
  end

  assign pend_add = pend_q + {{(CNT_W-1){1'b0}}, push};
  assign pend_d   = (act_f == ACT_HOLD) ? pend_add : '0;

  assign wr_o.we    = acc && push;
  assign wr_o.data  = in_byte_i;
  assign cmd_push_o = acc && (act_f != ACT_HOLD || in_last_i);
  assign cmd_o.keep   = (act_f == ACT_KEEP);
  assign cmd_o.n      = pend_add;
  assign cmd_o.last   = in_last_i;
  assign cmd_o.status = bad_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SOI0;
      pend_q  <= '0;
      bl_q    <= '0;
      exif_q  <= 1'b0;
      xmp_q   <= 1'b0;
      drop_q  <= 1'b0;
      bad_q   <= 1'b0;
      app1_q  <= 1'b0;
    end else if (acc) begin
      if (in_last_i) begin
        phase_q <= PH_SOI0;
        pend_q  <= '0;
        bl_q    <= '0;
        exif_q  <= 1'b0;
        xmp_q   <= 1'b0;
        drop_q  <= 1'b0;
        bad_q   <= 1'b0;
        app1_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pend_q  <= pend_d;
        bl_q    <= bl_d;
        exif_q  <= exif_d;
        xmp_q   <= xmp_d;
        drop_q  <= drop_d;
        bad_q   <= bad_d;
        app1_q  <= app1_d;
      end
    end
  end

endmodule

FILE: rtl/core/jaf_cmd_fifo.sv
// Four-entry command queue between the front end and the back end.
// Depends on jaf_pkg.
module jaf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jaf_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jaf_pkg::cmd_t head_o
);
  import jaf_pkg::*;

  cmd_t       slot_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = slot_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + 2'd1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/jaf_back.sv
// Back end: byte ring plus replay/discard engine and output register.
// Runs queued commands, one word per cycle unless the output is held.
// Depends on jaf_pkg.
module jaf_back #(
  parameter int HOLD_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jaf_pkg::ring_wr_t wr_i,
  output logic              ring_full_o,
  input  logic              cmd_valid_i,
  input  jaf_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_valid_o,
  output logic              out_last_o,
  output logic              status_o
);
  import jaf_pkg::*;

  localparam int PTR_W = $clog2(2 * HOLD_BYTES);
  localparam int RING  = 2 ** PTR_W;

  logic [7:0]       ring_mem [RING];
  logic [PTR_W:0]   wptr_q, rptr_q, rptr_d;
  logic [PTR_W:0]   used;
  logic [CNT_W-1:0] done_q, done_d, done_inc;
  logic [7:0]       rdata_q;
  logic             b_vld_q, b_end_q, b_last_q, b_status_q;
  logic             ov_q;
  logic [7:0]       obyte_q;
  logic             ovalid_q, olast_q, ostatus_q;

  logic advance, issue, keep_rd, rd_en, fin;

  assign used        = wptr_q - rptr_q;
  assign ring_full_o = used[PTR_W];

  assign advance  = !ov_q || res_ready_i;
  assign issue    = advance && cmd_valid_i;
  assign keep_rd  = cmd_i.keep && (cmd_i.n != '0);
  assign done_inc = done_q + {{(CNT_W-1){1'b0}}, 1'b1};
  assign fin      = (done_inc == cmd_i.n);
  assign rd_en    = issue && keep_rd;
  assign cmd_pop_o = issue && (!keep_rd || fin);

  always_comb begin
    rptr_d = rptr_q;
    done_d = done_q;
    if (rd_en) begin
      rptr_d = rptr_q + {{PTR_W{1'b0}}, 1'b1};
      done_d = fin ? '0 : done_inc;
    end else if (issue) begin
      rptr_d = rptr_q + {{(PTR_W+1-CNT_W){1'b0}}, cmd_i.n};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      ring_mem[wptr_q[PTR_W-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= ring_mem[rptr_q[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_end_q    <= !keep_rd;
      b_last_q   <= cmd_i.last && (!keep_rd || fin);
      b_status_q <= cmd_i.status;
      obyte_q    <= b_end_q ? 8'd0 : rdata_q;
      ovalid_q   <= !b_end_q;
      olast_q    <= b_last_q;
      ostatus_q  <= b_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      done_q  <= '0;
      b_vld_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (wr_i.we) begin
        wptr_q <= wptr_q + {{PTR_W{1'b0}}, 1'b1};
      end
      rptr_q <= rptr_d;
      done_q <= done_d;
      if (advance) begin
        b_vld_q <= issue && (keep_rd || cmd_i.last);
        ov_q    <= b_vld_q;
      end
    end
  end

  assign res_valid_o = ov_q;
  assign out_byte_o  = obyte_q;
  assign out_valid_o = ovalid_q;
  assign out_last_o  = olast_q;
  assign status_o    = ostatus_q;

  a_ring_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.we |-> !ring_full_o)
    else $error("byte ring written while full");

  a_ring_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (used != '0))
    else $error("byte ring read while empty");

  a_end_word_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && b_end_q) |-> b_last_q)
    else $error("end-only word without last flag");

endmodule

FILE: rtl/core/jpeg_app1_metadata_filter.sv
// Top level of the JPEG APP1 metadata filter.
// Holds the APB register file and ties front end, command queue and back end.
// Depends on jaf_pkg, jaf_front, jaf_cmd_fifo, jaf_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one file byte per word,
//   with in_last_i on the final byte. Result channel (res_valid_o/res_ready_i)
//   carries out_byte_o, out_valid_o, out_last_o and status_o. A word with
//   out_valid_o low is an end-only word that closes a file with no data.
//   A passed-through byte is registered in the byte ring, the read data
//   register and the output register. Held header and APP1 prefix bytes
//   (up to 32) are released when the segment is classified. Throughput: one
//   input byte per cycle; the output side moves one word per cycle unless
//   stalled, set by the single read port of the byte ring. Replay bursts
//   are absorbed by the ring (2*HOLD_BYTES rounded up to a power of two)
//   and a four-entry command queue; input stalls only when either is full.
//   When the receiver stalls, the output register holds and the ring fills.
//   Reset clears parser state and queues, and sets strip_exif and strip_xmp.
//   Registers: byte address 0 strip_exif (bit 0), byte address 4 strip_xmp.
module jpeg_app1_metadata_filter #(
  parameter int HOLD_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        out_last_o,
  output logic        status_o
);
  import jaf_pkg::*;

  localparam logic REG_STRIP_EXIF = 1'b0;
  localparam logic REG_STRIP_XMP  = 1'b1;

  logic     strip_exif_q, strip_xmp_q;
  logic     cfg_we;
  ring_wr_t ring_wr;
  logic     ring_full;
  logic     cmd_full, cmd_push, cmd_valid, cmd_pop;
  cmd_t     cmd_in, cmd_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = {31'd0, (paddr[2] == REG_STRIP_XMP) ? strip_xmp_q : strip_exif_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_exif_q <= 1'b1;
      strip_xmp_q  <= 1'b1;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_STRIP_EXIF: strip_exif_q <= pwdata[0];
        REG_STRIP_XMP:  strip_xmp_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  jaf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .strip_exif_i (strip_exif_q),
    .strip_xmp_i  (strip_xmp_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .ring_full_i  (ring_full),
    .cmd_full_i   (cmd_full),
    .wr_o         (ring_wr),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  jaf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .head_o  (cmd_head)
  );

  jaf_back #(
    .HOLD_BYTES (HOLD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (ring_wr),
    .ring_full_o (ring_full),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o)
  );

endmodule
